### src/line_pixel_generator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define LPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LPG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

    // Coordinate width, fixed by the item layout
    localparam int COORD_BITS = 6;
    // Signed error term: must hold -2*(2^COORD_BITS-1) up to 2^(COORD_BITS+1)-1
    localparam int ERR_BITS = COORD_BITS + 2;
    // Default depth of the command queue between front and back
    localparam int JOB_DEPTH_DEF = 2;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [COORD_BITS:0]       twice_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // One line command
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } line_cmd_t;

    // One pixel of a line
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

    // Classified line, ready for stepping
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        err_t   error_term;
        coord_t steps_left;   // pixels still to emit after the current one
        twice_t twice_dx;
        twice_t twice_dy;
        logic   x_negative;
        logic   y_negative;
        logic   x_major;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // One step along an axis, wrapping at the coordinate width
    function automatic coord_t step_coord(coord_t c, logic negative);
        coord_t r;
        r = negative ? (c - coord_t'(1)) : (c + coord_t'(1));
        return r;
    endfunction

endpackage

`default_nettype wire

### src/lpg_front.sv
`default_nettype none

module lpg_front (
    input  var lpg_pkg::line_cmd_t cmd,
    output var lpg_pkg::job_t      job
);
    import lpg_pkg::*;

    coord_t adx;
    coord_t ady;
    coord_t major_len;
    logic   x_major;

    // Absolute deltas and major axis; ties go to y
    always_comb
    begin
        adx       = (cmd.start_x >= cmd.end_x) ? (cmd.start_x - cmd.end_x)
                                               : (cmd.end_x - cmd.start_x);
        ady       = (cmd.start_y >= cmd.end_y) ? (cmd.start_y - cmd.end_y)
                                               : (cmd.end_y - cmd.start_y);
        x_major   = adx > ady;
        major_len = x_major ? adx : ady;
    end

    // Initial stepping state
    always_comb
    begin
        job.cur_x      = cmd.start_x;
        job.cur_y      = cmd.start_y;
        job.error_term = err_t'({2'b00, major_len});
        job.steps_left = major_len;
        job.twice_dx   = {adx, 1'b0};
        job.twice_dy   = {ady, 1'b0};
        job.x_negative = cmd.start_x > cmd.end_x;
        job.y_negative = cmd.start_y > cmd.end_y;
        job.x_major    = x_major;
    end

endmodule

`default_nettype wire

### src/lpg_job_queue.sv
`default_nettype none

module lpg_job_queue #(
    parameter int DEPTH = lpg_pkg::JOB_DEPTH_DEF
) (
    input  var logic          clk,
    input  var logic          rst_n,
    input  var logic          push,
    input  var lpg_pkg::job_t push_job,
    output var logic          full,
    input  var logic          pop,
    output var lpg_pkg::job_t head_job,
    output var logic          empty
);
    import lpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### src/lpg_back.sv
`default_nettype none

module lpg_back (
    input  var logic            clk,
    input  var logic            rst_n,
    input  var logic            job_empty,
    input  var lpg_pkg::job_t   head_job,
    output var logic            job_pop,
    output var lpg_pkg::pixel_t pixel,
    output var logic            empty,
    input  var logic            pop
);
    import lpg_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    pixel_t      out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    err_t   twice_minor;
    err_t   twice_major;
    err_t   err_dec;
    logic   minor_step;
    job_t   stepped;
    logic   advance;

    assign pixel = out_reg;
    assign empty = !out_valid_reg;

    // One midpoint step of the current line
    always_comb
    begin
        twice_minor = job_reg.x_major ? err_t'({1'b0, job_reg.twice_dy})
                                      : err_t'({1'b0, job_reg.twice_dx});
        twice_major = job_reg.x_major ? err_t'({1'b0, job_reg.twice_dx})
                                      : err_t'({1'b0, job_reg.twice_dy});
        err_dec     = job_reg.error_term - twice_minor;
        minor_step  = err_dec[ERR_BITS-1];
        stepped     = job_reg;
        stepped.error_term = minor_step ? (err_dec + twice_major) : err_dec;
        stepped.steps_left = job_reg.steps_left - 1'b1;
        if (job_reg.x_major || minor_step)
        begin
            stepped.cur_x = step_coord(job_reg.cur_x, job_reg.x_negative);
        end
        if (!job_reg.x_major || minor_step)
        begin
            stepped.cur_y = step_coord(job_reg.cur_y, job_reg.y_negative);
        end
    end

    // Emit a pixel when the output register is free or being taken
    assign advance = (state_reg == BK_RUN) && (!out_valid_reg || pop);

    // Sequencer: load a line, then one pixel per cycle while the output register is free or taken
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        job_pop        = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next   = head_job;
                    job_pop    = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (advance)
                begin
                    out_next.pixel_x    = job_reg.cur_x;
                    out_next.pixel_y    = job_reg.cur_y;
                    out_next.last_pixel = (job_reg.steps_left == '0);
                    out_valid_next      = 1'b1;
                    if (job_reg.steps_left == '0)
                    begin
                        // Chain straight into the next queued line
                        if (!job_empty)
                        begin
                            job_next = head_job;
                            job_pop  = 1'b1;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        job_next = stepped;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

### src/line_pixel_generator_unit.sv
// Channel   Direction  Handshake           Payload
// command   in         push / full         cmd   (start_x, start_y, end_x, end_y)
// pixel     out        empty / pop         pixel (pixel_x, pixel_y, last_pixel)
//
// A line of major delta D gives D+1 pixels, one per cycle from the back end's stepping
// unit while the result is free or popped; an idle back end first loads it in BK_IDLE.
// Up to JOB_DEPTH classified commands wait in a queue; full rises when it is full.
// A low pop stalls only the back end: the front keeps filling the queue until it is full.
// rst_n clears the queue, the sequencer and the result valid flag at once.
`default_nettype none

module line_pixel_generator_unit #(
    parameter int JOB_DEPTH = lpg_pkg::JOB_DEPTH_DEF
) (
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               push,
    output var logic               full,
    input  var lpg_pkg::line_cmd_t cmd,
    output var logic               empty,
    input  var logic               pop,
    output var lpg_pkg::pixel_t    pixel
);
    import lpg_pkg::*;

    job_t new_job;
    job_t head_job;
    logic job_empty;
    logic job_pop;

    // Front: classify the command
    lpg_front u_front (
        .cmd (cmd),
        .job (new_job)
    );

    // Decoupling queue
    lpg_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .full     (full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (job_empty)
    );

    // Back: step out the pixels
    lpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .head_job  (head_job),
        .job_pop   (job_pop),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

### src/lpg_checker.sv
`default_nettype none
`include "line_pixel_generator_unit_assert.svh"

module lpg_checker (
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               push,
    input  var logic               full,
    input  var logic               empty,
    input  var logic               pop,
    input  var lpg_pkg::pixel_t    pixel
);
    import lpg_pkg::*;

    logic [7:0] open_lines_reg, open_lines_next;
    coord_t     prev_x_reg, prev_y_reg;
    logic       mid_line_reg, mid_line_next;
    logic       cmd_in;
    logic       pix_out;
    coord_t     dx;
    coord_t     dy;
    logic       neighbor_ok;

    assign cmd_in  = push && !full;
    assign pix_out = pop && !empty;
    assign dx      = pixel.pixel_x - prev_x_reg;
    assign dy      = pixel.pixel_y - prev_y_reg;
    assign neighbor_ok = (dx == '0 || dx == coord_t'(1) || dx == '1)
                      && (dy == '0 || dy == coord_t'(1) || dy == '1)
                      && !(dx == '0 && dy == '0);

    // Lines accepted but not yet finished
    always_comb
    begin
        open_lines_next = open_lines_reg;
        if (cmd_in && !(pix_out && pixel.last_pixel))
        begin
            open_lines_next = open_lines_reg + 1'b1;
        end
        else if (!cmd_in && pix_out && pixel.last_pixel)
        begin
            open_lines_next = open_lines_reg - 1'b1;
        end
        mid_line_next = pix_out ? !pixel.last_pixel : mid_line_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_lines_reg <= '0;
            mid_line_reg   <= 1'b0;
        end
        else
        begin
            open_lines_reg <= open_lines_next;
            mid_line_reg   <= mid_line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_out)
        begin
            prev_x_reg <= pixel.pixel_x;
            prev_y_reg <= pixel.pixel_y;
        end
    end

    `LPG_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> empty, "result shown during reset")
    `LPG_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(pixel)), "stalled result changed")
    `LPG_ASSERT(a_no_phantom, !empty |-> (open_lines_reg != '0), "pixel with no open line")
    `LPG_ASSERT(a_adjacent, (pix_out && mid_line_reg) |-> neighbor_ok, "pixel not adjacent to previous")

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (.*);

`default_nettype wire

### tb/tb_line_pixel_generator_unit.sv
`default_nettype none

module tb_line_pixel_generator_unit;

    import lpg_pkg::*;

    // Cycles without any accepted item before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles to linger once nothing is expected
    localparam int TAIL_CYCLES = 70;
    localparam int IDLE_PCT    = 36;

    logic      clk   = 1'b0;
    logic      rst_n;
    logic      push  = 1'b0;
    logic      full;
    line_cmd_t cmd   = '0;
    logic      empty;
    logic      pop   = 1'b0;
    pixel_t    pixel;

    // Pixels still owed by the block, oldest first
    pixel_t    expected_pixels[$];

    // When set, neither side idles
    bit        steady = 1'b0;

    int        mismatches    = 0;
    int        lines_sent    = 0;
    int        pixels_seen   = 0;
    int        line_ends     = 0;
    int        quiet_cycles  = 0;

    line_pixel_generator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .cmd   (cmd),
        .empty (empty),
        .pop   (pop),
        .pixel (pixel)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Walk the line the way the rasterizer does and queue every pixel
    function automatic void rasterize_line(input line_cmd_t c);
        coord_t      x;
        coord_t      y;
        coord_t      dx_abs;
        coord_t      dy_abs;
        coord_t      major;
        twice_t      tdx;
        twice_t      tdy;
        err_t        err;
        logic        xneg;
        logic        yneg;
        logic        xmaj;
        int unsigned remaining;
        pixel_t      p;

        x      = c.start_x;
        y      = c.start_y;
        xneg   = c.start_x > c.end_x;
        yneg   = c.start_y > c.end_y;
        dx_abs = xneg ? coord_t'(c.start_x - c.end_x) : coord_t'(c.end_x - c.start_x);
        dy_abs = yneg ? coord_t'(c.start_y - c.end_y) : coord_t'(c.end_y - c.start_y);
        tdx    = {dx_abs, 1'b0};
        tdy    = {dy_abs, 1'b0};
        // ties go to the y-major loop
        xmaj   = dx_abs > dy_abs;
        major  = xmaj ? dx_abs : dy_abs;
        err    = $signed({2'b00, major});
        remaining = major + 1;

        while (remaining > 0)
        begin
            p.pixel_x    = x;
            p.pixel_y    = y;
            p.last_pixel = (remaining == 1);
            expected_pixels.push_back(p);
            remaining--;
            if (xmaj)
            begin
                x   = xneg ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
                err = err - $signed({1'b0, tdy});
                if (err < 0)
                begin
                    y   = yneg ? coord_t'(y - 1'b1) : coord_t'(y + 1'b1);
                    err = err + $signed({1'b0, tdx});
                end
            end
            else
            begin
                y   = yneg ? coord_t'(y - 1'b1) : coord_t'(y + 1'b1);
                err = err - $signed({1'b0, tdx});
                if (err < 0)
                begin
                    x   = xneg ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
                    err = err + $signed({1'b0, tdy});
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Pixel side: pop low in about a third of the cycles unless steady
    always @(negedge clk)
    begin
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: command acceptance, pixel checking and the stall watchdog
    always @(posedge clk)
    begin
        pixel_t want;
        bit     moved;

        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                rasterize_line(cmd);
                lines_sent++;
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                pixels_seen++;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("pixel count", pixels_seen, pixels_seen - 1);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel.pixel_x !== want.pixel_x)
                        report_mismatch("pixel_x", int'(pixel.pixel_x), int'(want.pixel_x));
                    if (pixel.pixel_y !== want.pixel_y)
                        report_mismatch("pixel_y", int'(pixel.pixel_y), int'(want.pixel_y));
                    if (pixel.last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", int'(pixel.last_pixel),
                                        int'(want.last_pixel));
                    if (want.last_pixel)
                        line_ends++;
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles, %0d pixels outstanding",
                         $time, STALL_LIMIT, expected_pixels.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one line command; entered and left just after a falling edge
    task automatic send_line(input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey);
        line_cmd_t c;

        c.start_x = sx;
        c.start_y = sy;
        c.end_x   = ex;
        c.end_y   = ey;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        cmd  <= c;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Short lines in about two fifths of the calls, full-range lines otherwise
    task automatic send_random_line();
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     tx;
        int     ty;

        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        if ($urandom_range(99) < 40)
        begin
            tx = int'(sx) + $urandom_range(16) - 8;
            ty = int'(sy) + $urandom_range(16) - 8;
            ex = (tx < 0) ? coord_t'(0) : (tx > 63) ? coord_t'(63) : coord_t'(tx);
            ey = (ty < 0) ? coord_t'(0) : (ty > 63) ? coord_t'(63) : coord_t'(ty);
        end
        else
        begin
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end
        send_line(sx, sy, ex, ey);
    endtask

    // Wait until every owed pixel has come out, then a little longer
    task automatic drain();
        push <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_zero_length();
        send_line(0, 0, 0, 0);
        send_line(63, 63, 63, 63);
        send_line(17, 42, 17, 42);
    endtask

    task automatic test_axis_lines();
        send_line(0, 0, 63, 0);
        send_line(63, 63, 0, 63);
        send_line(63, 0, 63, 63);
        send_line(0, 63, 0, 0);
        send_line(0, 0, 1, 0);
        send_line(0, 0, 0, 1);
    endtask

    // Equal deltas take the y-major loop; the last line is one step off the diagonal
    task automatic test_diagonals();
        send_line(0, 0, 63, 63);
        send_line(63, 63, 0, 0);
        send_line(0, 63, 63, 0);
        send_line(63, 0, 0, 63);
        send_line(5, 5, 6, 6);
        send_line(0, 0, 63, 62);
    endtask

    // Shallow and steep lines in every direction
    task automatic test_octants();
        send_line(10, 20, 40, 27);
        send_line(40, 27, 10, 20);
        send_line(10, 27, 40, 20);
        send_line(40, 20, 10, 27);
        send_line(20, 10, 27, 40);
        send_line(27, 40, 20, 10);
        send_line(27, 10, 20, 40);
        send_line(20, 40, 27, 10);
    endtask

    // Commands every cycle while the queue is not full, and pops every cycle
    task automatic test_back_to_back(input int n);
        steady = 1'b1;
        repeat (n) send_random_line();
        steady = 1'b0;
    endtask

    task automatic test_random_lines(input int n);
        repeat (n) send_random_line();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_length();
        test_axis_lines();
        test_diagonals();
        test_octants();
        drain();
        test_random_lines(200);
        test_back_to_back(80);
        test_random_lines(170);
        drain();

        $display("Drew %0d lines, %0d pixels checked, %0d line ends marked", lines_sent,
                 pixels_seen, line_ends);
        $display("Zero-length, axis, diagonal, octant, back-to-back and random lines");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/lpg_pkg.sv
src/lpg_front.sv
src/lpg_job_queue.sv
src/lpg_back.sv
src/line_pixel_generator_unit.sv
src/lpg_checker.sv
tb/tb_line_pixel_generator_unit.sv
